// ===== rtl/socks5_request_parser_core_defines.svh =====
// ----------------------------------------------------------------------------
// SOCKS5 request parser assertion macros
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef SOCKS5_REQUEST_PARSER_CORE_DEFINES_SVH
`define SOCKS5_REQUEST_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define S5RP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is held
`define S5RP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/s5rp_pkg.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 request parser package
// Codes, protocol constants and shared types of the parser core.
// ----------------------------------------------------------------------------
package s5rp_pkg;

  localparam int unsigned OutTdataW = 176;

  // protocol bytes
  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] REP_UNSUP   = 8'h07;
  localparam logic [7:0] METH_NOAUTH = 8'h00;
  localparam logic [7:0] METH_REJECT = 8'hFF;
  localparam logic [7:0] RSV_BYTE    = 8'h00;
  localparam logic [7:0] IPV4_BYTES  = 8'd4;
  localparam logic [7:0] IPV6_BYTES  = 8'd16;

  typedef enum logic [3:0] {
    PH_GVER, PH_GCNT, PH_GMETH, PH_RVER, PH_RCMD, PH_RRSV, PH_RATYP,
    PH_IPV4, PH_IPV6, PH_DLEN, PH_DNAME, PH_PORTH, PH_PORTL, PH_DONE
  } phase_e;

  typedef enum logic [3:0] {
    ST_OK, ST_TRUNC, ST_GREET_VER, ST_NO_METHOD, ST_REQ_VER,
    ST_RESERVED, ST_ADDR_TYPE, ST_NO_DEST, ST_UNSUP_CMD
  } status_e;

  typedef enum logic [1:0] {
    KIND_REPLY, KIND_DOMAIN, KIND_RECORD, KIND_ERROR
  } kind_e;

  typedef enum logic [1:0] {
    ADDR_IPV4, ADDR_IPV6, ADDR_DOMAIN
  } addr_e;

  // group of results caused by one input byte
  typedef enum logic [2:0] {
    BND_ERR,     // one error record
    BND_DOMAIN,  // one domain byte
    BND_RECORD,  // one request record
    BND_ACCEPT,  // 05 00
    BND_REJECT,  // 05 FF, error record
    BND_UNSUP    // 05 07 00, error record with request fields
  } bnd_e;

  typedef struct packed {
    logic       valid;
    bnd_e       kind;
    logic [7:0] data;
    status_e    status;
  } bundle_t;

  typedef struct packed {
    logic [7:0]  command;
    addr_e       addr_kind;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [7:0]  name_len;
  } req_t;

endpackage

// ===== rtl/s5rp_parser.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 request parser - session state
// Steps the greeting/request phase machine one accepted byte at a time.
// ----------------------------------------------------------------------------
module s5rp_parser (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic              func_i,
  input  logic [7:0]        byte_i,
  output s5rp_pkg::bundle_t bundle_o,
  output s5rp_pkg::req_t    req_o
);

  s5rp_pkg::phase_e phase_q, phase_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             none_q, none_d;
  s5rp_pkg::req_t   req_q, req_d;

  logic [7:0]  cnt_dec;
  logic        none_upd;
  logic [15:0] port_full;
  logic        no_dest;

  assign cnt_dec   = cnt_q - 8'd1;
  assign none_upd  = none_q | (byte_i == s5rp_pkg::METH_NOAUTH);
  assign port_full = {req_q.port[15:8], byte_i};
  assign no_dest   = ((req_q.addr_kind == s5rp_pkg::ADDR_DOMAIN) && (req_q.name_len == 8'd0))
                     || (port_full == 16'd0);

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    none_d  = none_q;
    req_d   = req_q;
    if (accept_i) begin
      if (func_i) begin
        phase_d = s5rp_pkg::PH_GVER;
        cnt_d   = '0;
        none_d  = 1'b0;
        req_d   = '0;
      end else begin
        unique case (phase_q)
          s5rp_pkg::PH_GVER: begin
            phase_d = (byte_i == s5rp_pkg::SOCKS_VER) ? s5rp_pkg::PH_GCNT : s5rp_pkg::PH_DONE;
          end
          s5rp_pkg::PH_GCNT: begin
            if (byte_i == 8'd0) begin
              phase_d = s5rp_pkg::PH_RVER;
            end else begin
              cnt_d   = byte_i;
              none_d  = 1'b0;
              phase_d = s5rp_pkg::PH_GMETH;
            end
          end
          s5rp_pkg::PH_GMETH: begin
            none_d = none_upd;
            cnt_d  = cnt_dec;
            if (cnt_dec == 8'd0) begin
              phase_d = none_upd ? s5rp_pkg::PH_RVER : s5rp_pkg::PH_DONE;
            end
          end
          s5rp_pkg::PH_RVER: begin
            phase_d = (byte_i == s5rp_pkg::SOCKS_VER) ? s5rp_pkg::PH_RCMD : s5rp_pkg::PH_DONE;
          end
          s5rp_pkg::PH_RCMD: begin
            req_d.command = byte_i;
            phase_d       = s5rp_pkg::PH_RRSV;
          end
          s5rp_pkg::PH_RRSV: begin
            phase_d = (byte_i == s5rp_pkg::RSV_BYTE) ? s5rp_pkg::PH_RATYP : s5rp_pkg::PH_DONE;
          end
          s5rp_pkg::PH_RATYP: begin
            if (byte_i == s5rp_pkg::ATYP_IPV4) begin
              req_d.addr_kind = s5rp_pkg::ADDR_IPV4;
              cnt_d           = s5rp_pkg::IPV4_BYTES;
              phase_d         = s5rp_pkg::PH_IPV4;
            end else if (byte_i == s5rp_pkg::ATYP_IPV6) begin
              req_d.addr_kind = s5rp_pkg::ADDR_IPV6;
              cnt_d           = s5rp_pkg::IPV6_BYTES;
              phase_d         = s5rp_pkg::PH_IPV6;
            end else if (byte_i == s5rp_pkg::ATYP_DOMAIN) begin
              req_d.addr_kind = s5rp_pkg::ADDR_DOMAIN;
              phase_d         = s5rp_pkg::PH_DLEN;
            end else begin
              phase_d = s5rp_pkg::PH_DONE;
            end
          end
          s5rp_pkg::PH_IPV4: begin
            req_d.addr_low = {32'd0, req_q.addr_low[23:0], byte_i};
            cnt_d          = cnt_dec;
            if (cnt_dec == 8'd0) phase_d = s5rp_pkg::PH_PORTH;
          end
          s5rp_pkg::PH_IPV6: begin
            req_d.addr_high = {req_q.addr_high[55:0], req_q.addr_low[63:56]};
            req_d.addr_low  = {req_q.addr_low[55:0], byte_i};
            cnt_d           = cnt_dec;
            if (cnt_dec == 8'd0) phase_d = s5rp_pkg::PH_PORTH;
          end
          s5rp_pkg::PH_DLEN: begin
            req_d.name_len = byte_i;
            cnt_d          = byte_i;
            phase_d = (byte_i == 8'd0) ? s5rp_pkg::PH_PORTH : s5rp_pkg::PH_DNAME;
          end
          s5rp_pkg::PH_DNAME: begin
            cnt_d = cnt_dec;
            if (cnt_dec == 8'd0) phase_d = s5rp_pkg::PH_PORTH;
          end
          s5rp_pkg::PH_PORTH: begin
            req_d.port = {byte_i, 8'd0};
            phase_d    = s5rp_pkg::PH_PORTL;
          end
          s5rp_pkg::PH_PORTL: begin
            req_d.port = port_full;
            phase_d    = s5rp_pkg::PH_DONE;
          end
          default: phase_d = s5rp_pkg::PH_DONE;
        endcase
      end
    end
  end

  // results caused by the accepted byte
  always_comb begin
    bundle_o = '0;
    if (accept_i) begin
      if (func_i) begin
        if ((phase_q != s5rp_pkg::PH_GVER) && (phase_q != s5rp_pkg::PH_DONE)) begin
          bundle_o.valid  = 1'b1;
          bundle_o.kind   = s5rp_pkg::BND_ERR;
          bundle_o.status = s5rp_pkg::ST_TRUNC;
        end
      end else begin
        unique case (phase_q)
          s5rp_pkg::PH_GVER: begin
            if (byte_i != s5rp_pkg::SOCKS_VER) begin
              bundle_o.valid  = 1'b1;
              bundle_o.kind   = s5rp_pkg::BND_ERR;
              bundle_o.status = s5rp_pkg::ST_GREET_VER;
            end
          end
          s5rp_pkg::PH_GCNT: begin
            if (byte_i == 8'd0) begin
              bundle_o.valid = 1'b1;
              bundle_o.kind  = s5rp_pkg::BND_ACCEPT;
            end
          end
          s5rp_pkg::PH_GMETH: begin
            if (cnt_dec == 8'd0) begin
              bundle_o.valid = 1'b1;
              bundle_o.kind  = none_upd ? s5rp_pkg::BND_ACCEPT : s5rp_pkg::BND_REJECT;
            end
          end
          s5rp_pkg::PH_RVER: begin
            if (byte_i != s5rp_pkg::SOCKS_VER) begin
              bundle_o.valid  = 1'b1;
              bundle_o.kind   = s5rp_pkg::BND_ERR;
              bundle_o.status = s5rp_pkg::ST_REQ_VER;
            end
          end
          s5rp_pkg::PH_RRSV: begin
            if (byte_i != s5rp_pkg::RSV_BYTE) begin
              bundle_o.valid  = 1'b1;
              bundle_o.kind   = s5rp_pkg::BND_ERR;
              bundle_o.status = s5rp_pkg::ST_RESERVED;
            end
          end
          s5rp_pkg::PH_RATYP: begin
            if ((byte_i != s5rp_pkg::ATYP_IPV4) && (byte_i != s5rp_pkg::ATYP_IPV6)
                && (byte_i != s5rp_pkg::ATYP_DOMAIN)) begin
              bundle_o.valid  = 1'b1;
              bundle_o.kind   = s5rp_pkg::BND_ERR;
              bundle_o.status = s5rp_pkg::ST_ADDR_TYPE;
            end
          end
          s5rp_pkg::PH_DNAME: begin
            bundle_o.valid = 1'b1;
            bundle_o.kind  = s5rp_pkg::BND_DOMAIN;
            bundle_o.data  = byte_i;
          end
          s5rp_pkg::PH_PORTL: begin
            bundle_o.valid = 1'b1;
            if (no_dest) begin
              bundle_o.kind   = s5rp_pkg::BND_ERR;
              bundle_o.status = s5rp_pkg::ST_NO_DEST;
            end else if (req_q.command == s5rp_pkg::CMD_CONNECT) begin
              bundle_o.kind = s5rp_pkg::BND_RECORD;
            end else begin
              bundle_o.kind = s5rp_pkg::BND_UNSUP;
            end
          end
          default: bundle_o = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= s5rp_pkg::PH_GVER;
      cnt_q   <= '0;
      none_q  <= 1'b0;
      req_q   <= '0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      none_q  <= none_d;
      req_q   <= req_d;
    end
  end

  assign req_o = req_q;

endmodule

// ===== rtl/s5rp_emitter.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 request parser - result sequencer
// Holds the results of one byte and hands them out one transfer at a time.
// ----------------------------------------------------------------------------
module s5rp_emitter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  s5rp_pkg::bundle_t                    bundle_i,
  input  s5rp_pkg::req_t                       req_i,
  output logic                                 free_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [s5rp_pkg::OutTdataW-1:0]       m_axis_tdata,
  output logic [1:0]                           m_axis_tuser,
  output logic                                 m_axis_tlast
);

  logic              valid_q, valid_d;
  logic [1:0]        idx_q, idx_d;
  s5rp_pkg::bnd_e    bnd_q;
  logic [7:0]        data_q;
  s5rp_pkg::status_e status_q;

  logic [1:0]        last_idx;
  logic              take;
  logic              is_last;
  s5rp_pkg::kind_e   kind;
  logic [7:0]        out_byte;
  s5rp_pkg::status_e status;
  logic              full;
  s5rp_pkg::req_t    req_out;

  always_comb begin
    case (bnd_q)
      s5rp_pkg::BND_ACCEPT: last_idx = 2'd1;
      s5rp_pkg::BND_REJECT: last_idx = 2'd2;
      s5rp_pkg::BND_UNSUP:  last_idx = 2'd3;
      default:              last_idx = 2'd0;
    endcase
  end

  assign take    = valid_q & m_axis_tready;
  assign is_last = (idx_q == last_idx);
  assign free_o  = !valid_q || (take && is_last);

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (bundle_i.valid) begin
      valid_d = 1'b1;
      idx_d   = '0;
    end else if (take && is_last) begin
      valid_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  // result fields from the held group and the position in it
  always_comb begin
    kind     = s5rp_pkg::KIND_REPLY;
    out_byte = '0;
    status   = s5rp_pkg::ST_OK;
    full     = 1'b0;
    case (bnd_q)
      s5rp_pkg::BND_ERR: begin
        kind   = s5rp_pkg::KIND_ERROR;
        status = status_q;
      end
      s5rp_pkg::BND_DOMAIN: begin
        kind     = s5rp_pkg::KIND_DOMAIN;
        out_byte = data_q;
      end
      s5rp_pkg::BND_RECORD: begin
        kind = s5rp_pkg::KIND_RECORD;
        full = 1'b1;
      end
      s5rp_pkg::BND_ACCEPT: begin
        out_byte = (idx_q == 2'd0) ? s5rp_pkg::SOCKS_VER : s5rp_pkg::METH_NOAUTH;
      end
      s5rp_pkg::BND_REJECT: begin
        case (idx_q)
          2'd0:    out_byte = s5rp_pkg::SOCKS_VER;
          2'd1:    out_byte = s5rp_pkg::METH_REJECT;
          default: begin
            kind   = s5rp_pkg::KIND_ERROR;
            status = s5rp_pkg::ST_NO_METHOD;
          end
        endcase
      end
      s5rp_pkg::BND_UNSUP: begin
        case (idx_q)
          2'd0:    out_byte = s5rp_pkg::SOCKS_VER;
          2'd1:    out_byte = s5rp_pkg::REP_UNSUP;
          2'd2:    out_byte = 8'h00;
          default: begin
            kind   = s5rp_pkg::KIND_ERROR;
            status = s5rp_pkg::ST_UNSUP_CMD;
            full   = 1'b1;
          end
        endcase
      end
      default: kind = s5rp_pkg::KIND_REPLY;
    endcase
  end

  assign req_out = full ? req_i : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (bundle_i.valid) begin
      bnd_q    <= bundle_i.kind;
      data_q   <= bundle_i.data;
      status_q <= bundle_i.status;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = kind;
  assign m_axis_tlast  = is_last;
  assign m_axis_tdata  = {2'b00, req_out.name_len, req_out.port, req_out.addr_low,
                          req_out.addr_high, req_out.addr_kind, req_out.command,
                          status, out_byte};

endmodule

// ===== rtl/socks5_request_parser_core.sv =====
// SOCKS5 request parser core.
// Slave stream: one received client byte per transfer; tuser high marks a
// connection close / new session instead of a data byte.
// Master stream: one result per transfer; tuser gives the kind (reply byte,
// domain byte, request record, session error), tlast marks the final result
// caused by one input transfer.
// Each byte is parsed in the cycle it is accepted and its results are
// registered, so the first result appears in the cycle after acceptance.
// Throughput is one byte per cycle while each byte gives at most one result
// and the master side takes every result. A byte with several results
// (greeting reply, reject, unsupported command) holds the result register
// until all of them are taken; the next byte is taken in the same cycle as
// the last of them. When the master side stalls, s_axis_tready drops as
// soon as the held results are not being drained, and nothing is lost.
// Reset clears the session to wait for the greeting version byte and
// empties the result register.
// ----------------------------------------------------------------------------
// SOCKS5 request parser core
// Top level: phase machine feeding a multi-result output sequencer.
// ----------------------------------------------------------------------------
module socks5_request_parser_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] data_byte
  input  logic                           s_axis_tuser,  // [0] func
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] out_byte, [11:8] status, [19:12] command, [21:20] address_kind,
  // [85:22] address_high, [149:86] address_low, [165:150] dest_port,
  // [173:166] domain_length, [175:174] zero
  output logic [s5rp_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] kind
  output logic                           m_axis_tlast
);

  logic              accept;
  logic              free;
  s5rp_pkg::bundle_t bundle;
  s5rp_pkg::req_t    req;

  assign s_axis_tready = free;
  assign accept        = s_axis_tvalid & free;

  s5rp_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .func_i   (s_axis_tuser),
    .byte_i   (s_axis_tdata),
    .bundle_o (bundle),
    .req_o    (req)
  );

  s5rp_emitter u_emitter (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .bundle_i      (bundle),
    .req_i         (req),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/s5rp_checker.sv =====
// ----------------------------------------------------------------------------
// SOCKS5 request parser checker
// Port-level assertions on the parser core, attached by bind.
// ----------------------------------------------------------------------------
`include "socks5_request_parser_core_defines.svh"

module s5rp_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [7:0]                     s_axis_tdata,
  input logic                           s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [s5rp_pkg::OutTdataW-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser,
  input logic                           m_axis_tlast
);

  logic out_stall;
  logic in_stall;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign in_stall  = s_axis_tvalid && !s_axis_tready;

  `S5RP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
                   "stalled result changed")

  // a waiting input transfer is held by the sender
  `S5RP_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_stall,
                   s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser),
                   "stalled input transfer changed")

  // an empty result register always takes input
  `S5RP_ASSERT_IMP(a_ready_when_empty, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready,
                   "input blocked with no pending result")

  // a pending result that is not the last of its group blocks input
  `S5RP_ASSERT_IMP(a_block_mid_group, clk_i, rst_ni, m_axis_tvalid && !m_axis_tlast,
                   !s_axis_tready, "input taken while results remain")

  // domain bytes and request records are single results
  `S5RP_ASSERT_IMP(a_single_result, clk_i, rst_ni,
                   m_axis_tvalid && (m_axis_tuser == s5rp_pkg::KIND_DOMAIN ||
                   m_axis_tuser == s5rp_pkg::KIND_RECORD),
                   m_axis_tlast && (m_axis_tdata[11:8] == s5rp_pkg::ST_OK),
                   "domain byte or record not a lone ok result")

endmodule

bind socks5_request_parser_core s5rp_checker u_s5rp_checker (.*);
